@@ sv/htw_pkg.sv @@
// Shared types and constants of the hierarchical timing wheel.
package htw_pkg;

    localparam int NUM_LEVELS = 4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_ADDED   = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;
    localparam logic [1:0] KIND_IDLE    = 2'd3;

    // Command word held in the queue between front and back
    typedef struct packed {
        logic        cmd;
        logic [30:0] delay;
        logic [31:0] handle;
        logic [31:0] session;
    } cmd_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_POP,
        ST_ADD_FILE,
        ST_TICK_HEAD,
        ST_EXP_RD,
        ST_EXP_OUT,
        ST_ADV,
        ST_RF_HEAD,
        ST_RF_RD,
        ST_RF_FILE,
        ST_RF_LINK,
        ST_DONE
    } back_state_t;

endpackage

@@ sv/htw_ram.sv @@
// Generic single-write, registered-read RAM.
module htw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/htw_front.sv @@
// Front end: takes command words and buffers them in a short queue.
module htw_front #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  htw_pkg::cmd_word_t in_word,
    output logic               q_valid,
    input  logic               q_pop,
    output htw_pkg::cmd_word_t q_word
);

    localparam int AW = $clog2(DEPTH);

    htw_pkg::cmd_word_t buf_reg [DEPTH];
    logic [AW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push, pop;

    assign in_ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_word   = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Advance queue pointers
    always_comb
    begin
        rd_next  = pop  ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        wr_next  = push ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_word;
        end
    end

endmodule

@@ sv/htw_back.sv @@
// Back end: wheel state machine, node pool and slot lists.
module htw_back #(
    parameter int NEAR_BITS   = 8,
    parameter int LEVEL_BITS  = 6,
    parameter int TIMER_SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  htw_pkg::cmd_word_t q_word,
    output logic [1:0]         kind,
    output logic [31:0]        out_handle,
    output logic [31:0]        out_session,
    output logic               last,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int NW         = $clog2(TIMER_SLOTS);
    localparam int NEAR_COUNT = 1 << NEAR_BITS;
    localparam int LEVEL_CNT  = (1 << LEVEL_BITS) - 1;
    localparam int SLOTS      = NEAR_COUNT + htw_pkg::NUM_LEVELS * LEVEL_CNT;
    localparam int SW         = $clog2(SLOTS);
    localparam int CW         = NW + 1;
    localparam int SE         = 2 * NW + 1;
    localparam int EF         = 2 * NW;

    htw_pkg::back_state_t state_reg, state_next;

    logic [31:0]  tick_reg, tick_next;
    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [SW-1:0] clr_reg, clr_next;
    htw_pkg::cmd_word_t cur_reg, cur_next;
    logic [NW-1:0] node_reg, node_next_v, tail_reg, tail_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [1:0]  okind_reg, okind_next;
    logic [31:0] oh_reg, oh_next, os_reg, os_next;
    logic        olast_reg, olast_next, ov_reg, ov_next;
    logic        any_reg, any_next;
    logic        end_reg, end_next;

    // Node memories
    logic          n_we;
    logic [NW-1:0] n_waddr, n_raddr;
    logic [31:0]   exp_wd, exp_rd, hd_wd, hd_rd, ss_wd, ss_rd;
    logic          nx_we;
    logic [NW-1:0] nx_waddr, nx_wd, nx_rd;
    logic          s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    logic [SE-1:0] s_wd, s_rd;   // {empty, head, tail}
    logic          fs_we;
    logic [NW-1:0] fs_waddr, fs_wd, fs_raddr, fs_rd;

    htw_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_exp (.clk(clk), .we(n_we),
        .waddr(n_waddr), .wdata(exp_wd), .raddr(n_raddr), .rdata(exp_rd));
    htw_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_hdl (.clk(clk), .we(n_we),
        .waddr(n_waddr), .wdata(hd_wd), .raddr(n_raddr), .rdata(hd_rd));
    htw_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_ses (.clk(clk), .we(n_we),
        .waddr(n_waddr), .wdata(ss_wd), .raddr(n_raddr), .rdata(ss_rd));
    htw_ram #(.WIDTH(NW), .DEPTH(TIMER_SLOTS)) u_nxt (.clk(clk), .we(nx_we),
        .waddr(nx_waddr), .wdata(nx_wd), .raddr(n_raddr), .rdata(nx_rd));
    htw_ram #(.WIDTH(SE), .DEPTH(SLOTS)) u_slot (.clk(clk), .we(s_we),
        .waddr(s_waddr), .wdata(s_wd), .raddr(s_raddr), .rdata(s_rd));
    htw_ram #(.WIDTH(NW), .DEPTH(TIMER_SLOTS)) u_free (.clk(clk), .we(fs_we),
        .waddr(fs_waddr), .wdata(fs_wd), .raddr(fs_raddr), .rdata(fs_rd));

    // Slot selection for an expiry against the current tick
    function automatic logic [SW-1:0] pick_slot(input logic [31:0] e, input logic [31:0] c);
        logic [63:0] m;
        logic [63:0] ee;
        logic [SW-1:0] r;
        int lvl;
        int sh;
        logic [LEVEL_BITS-1:0] d;
        ee  = {32'd0, e};
        lvl = htw_pkg::NUM_LEVELS - 1;
        if ((e >> NEAR_BITS) == (c >> NEAR_BITS))
        begin
            r = SW'(e[NEAR_BITS-1:0]);
        end
        else
        begin
            for (int i = htw_pkg::NUM_LEVELS - 2; i >= 0; i--)
            begin
                m = (64'd1 << (NEAR_BITS + (i + 1) * LEVEL_BITS)) - 64'd1;
                if ((({32'd0, e} | m) == ({32'd0, c} | m)))
                begin
                    lvl = i;
                end
            end
            sh = NEAR_BITS + lvl * LEVEL_BITS;
            d  = LEVEL_BITS'(ee >> sh);
            r  = SW'(NEAR_COUNT + lvl * LEVEL_CNT)
                 + ((d == '0) ? SW'(LEVEL_CNT - 1) : SW'(d) - SW'(1));
        end
        return r;
    endfunction

    // Level slot to re-file after the count advances
    function automatic logic [SW-1:0] refile_slot(input logic [31:0] t);
        logic [63:0] tt;
        logic [SW-1:0] r;
        logic [LEVEL_BITS-1:0] d;
        logic found;
        tt    = {32'd0, t};
        found = 1'b0;
        r     = SW'(SLOTS - 1);
        for (int i = 0; i < htw_pkg::NUM_LEVELS; i++)
        begin
            d = LEVEL_BITS'(tt >> (NEAR_BITS + i * LEVEL_BITS));
            if (!found && d != '0)
            begin
                found = 1'b1;
                r = SW'(NEAR_COUNT + i * LEVEL_CNT) + SW'(d) - SW'(1);
            end
        end
        return r;
    endfunction

    logic [SW-1:0] file_slot;
    logic [31:0]   file_exp;
    logic [SW-1:0] rf_slot;

    assign rf_slot = refile_slot(tick_reg + 32'd1);

    assign kind        = okind_reg;
    assign out_handle  = oh_reg;
    assign out_session = os_reg;
    assign last        = olast_reg;
    assign out_valid   = ov_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        free_cnt_next = free_cnt_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        node_next_v   = node_reg;
        tail_next     = tail_reg;
        slot_next     = slot_reg;
        okind_next    = okind_reg;
        oh_next       = oh_reg;
        os_next       = os_reg;
        olast_next    = olast_reg;
        ov_next       = ov_reg && !out_ready;
        any_next      = any_reg;
        end_next      = end_reg;
        q_pop         = 1'b0;
        n_we = 1'b0; n_waddr = node_reg; n_raddr = node_reg;
        exp_wd = '0; hd_wd = cur_reg.handle; ss_wd = cur_reg.session;
        nx_we = 1'b0; nx_waddr = '0; nx_wd = node_reg;
        s_we = 1'b0; s_waddr = slot_reg; s_wd = {1'b0, node_reg, node_reg};
        s_raddr = slot_reg;
        fs_we = 1'b0; fs_waddr = NW'(free_cnt_reg); fs_wd = node_reg;
        fs_raddr = NW'(free_cnt_reg - CW'(1));
        file_exp  = (state_reg == htw_pkg::ST_ADD_FILE) ? tick_reg + {1'b0, cur_reg.delay}
                                                        : exp_rd;
        file_slot = pick_slot(file_exp, tick_reg);

        unique case (state_reg)
            htw_pkg::ST_CLEAR:
            begin
                // Mark every slot empty and load the free stack
                s_we = 1'b1; s_waddr = clr_reg; s_wd = {1'b1, {(2*NW){1'b0}}};
                if (clr_reg < SW'(TIMER_SLOTS))
                begin
                    fs_we = 1'b1; fs_waddr = NW'(clr_reg); fs_wd = NW'(clr_reg);
                end
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            htw_pkg::ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_word;
                    any_next = 1'b0;
                    if (q_word.cmd == htw_pkg::CMD_TICK)
                    begin
                        slot_next  = SW'(tick_reg[NEAR_BITS-1:0]);
                        s_raddr    = SW'(tick_reg[NEAR_BITS-1:0]);
                        state_next = htw_pkg::ST_TICK_HEAD;
                    end
                    else
                    begin
                        state_next = htw_pkg::ST_ADD_POP;
                    end
                end
            end
            htw_pkg::ST_ADD_POP:
            begin
                if (cur_reg.delay == '0 || free_cnt_reg == '0)
                begin
                    okind_next = (cur_reg.delay == '0) ? htw_pkg::KIND_EXPIRED
                                                       : htw_pkg::KIND_FULL;
                    oh_next = cur_reg.handle; os_next = cur_reg.session;
                    olast_next = 1'b1; ov_next = 1'b1;
                    state_next = htw_pkg::ST_IDLE;
                end
                else
                begin
                    free_cnt_next = free_cnt_reg - CW'(1);
                    node_next_v   = fs_rd;
                    state_next    = htw_pkg::ST_ADD_FILE;
                end
                s_raddr = pick_slot(tick_reg + {1'b0, cur_reg.delay}, tick_reg);
            end
            htw_pkg::ST_ADD_FILE:
            begin
                // Write the node, link it at the slot's tail
                n_we = 1'b1; exp_wd = file_exp;
                s_we = 1'b1; s_waddr = file_slot;
                if (!s_rd[EF])
                begin
                    s_wd = {1'b0, s_rd[2*NW-1:NW], node_reg};
                    nx_we = 1'b1; nx_waddr = s_rd[NW-1:0];
                end
                okind_next = htw_pkg::KIND_ADDED;
                oh_next = cur_reg.handle; os_next = cur_reg.session;
                olast_next = 1'b1; ov_next = 1'b1;
                state_next = htw_pkg::ST_IDLE;
            end
            htw_pkg::ST_TICK_HEAD:
            begin
                if (!s_rd[EF])
                begin
                    s_we = 1'b1; s_wd = {1'b1, s_rd[2*NW-1:0]};
                    node_next_v = s_rd[2*NW-1:NW];
                    tail_next   = s_rd[NW-1:0];
                    state_next  = htw_pkg::ST_EXP_RD;
                end
                else
                begin
                    state_next = htw_pkg::ST_ADV;
                end
            end
            htw_pkg::ST_EXP_RD:
            begin
                end_next = (node_reg == tail_reg);
                if (!ov_reg || out_ready)
                begin
                    state_next = htw_pkg::ST_EXP_OUT;
                end
            end
            htw_pkg::ST_EXP_OUT:
            begin
                // Emit the timer and push its node back on the free stack
                if (!ov_reg || out_ready)
                begin
                    okind_next = htw_pkg::KIND_EXPIRED;
                    oh_next = hd_rd; os_next = ss_rd;
                    olast_next = end_reg; ov_next = 1'b1;
                    any_next = 1'b1;
                    fs_we = 1'b1;
                    free_cnt_next = free_cnt_reg + CW'(1);
                    node_next_v = nx_rd;
                    state_next  = end_reg ? htw_pkg::ST_ADV : htw_pkg::ST_EXP_RD;
                end
            end
            htw_pkg::ST_ADV:
            begin
                tick_next = tick_reg + 32'd1;
                slot_next = rf_slot;
                s_raddr   = rf_slot;
                if (tick_next[NEAR_BITS-1:0] == '0)
                begin
                    state_next = htw_pkg::ST_RF_HEAD;
                end
                else
                begin
                    state_next = htw_pkg::ST_DONE;
                end
            end
            htw_pkg::ST_RF_HEAD:
            begin
                if (!s_rd[EF])
                begin
                    s_we = 1'b1; s_wd = {1'b1, s_rd[2*NW-1:0]};
                    node_next_v = s_rd[2*NW-1:NW];
                    tail_next   = s_rd[NW-1:0];
                    state_next  = htw_pkg::ST_RF_RD;
                end
                else
                begin
                    state_next = htw_pkg::ST_DONE;
                end
            end
            htw_pkg::ST_RF_RD:
            begin
                end_next   = (node_reg == tail_reg);
                state_next = htw_pkg::ST_RF_FILE;
            end
            htw_pkg::ST_RF_FILE:
            begin
                // Read the target slot of the node's expiry
                s_raddr    = file_slot;
                slot_next  = file_slot;
                state_next = htw_pkg::ST_RF_LINK;
            end
            htw_pkg::ST_RF_LINK:
            begin
                // Append the node at the target slot's tail
                s_we = 1'b1;
                if (!s_rd[EF])
                begin
                    s_wd = {1'b0, s_rd[2*NW-1:NW], node_reg};
                    nx_we = 1'b1; nx_waddr = s_rd[NW-1:0];
                end
                node_next_v = nx_rd;
                state_next  = end_reg ? htw_pkg::ST_DONE : htw_pkg::ST_RF_RD;
            end
            htw_pkg::ST_DONE:
            begin
                if (any_reg)
                begin
                    state_next = htw_pkg::ST_IDLE;
                end
                else if (!ov_reg || out_ready)
                begin
                    okind_next = htw_pkg::KIND_IDLE;
                    oh_next = '0; os_next = '0; olast_next = 1'b1;
                    ov_next = 1'b1;
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= htw_pkg::ST_CLEAR;
            tick_reg     <= '0;
            free_cnt_reg <= CW'(TIMER_SLOTS);
            clr_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            free_cnt_reg <= free_cnt_next;
            clr_reg      <= clr_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        node_reg  <= node_next_v;
        tail_reg  <= tail_next;
        slot_reg  <= slot_next;
        okind_reg <= okind_next;
        oh_reg    <= oh_next;
        os_reg    <= os_next;
        olast_reg <= olast_next;
        any_reg   <= any_next;
        end_reg   <= end_next;
    end

endmodule

@@ sv/hierarchical_timing_wheel_unit.sv @@
// Top level of the hierarchical timing wheel.
//
// Slave channel s_axis_*: one command word per add or tick.
// Master channel m_axis_*: result words; tlast marks the final result of a
// command, tuser carries the result kind (expired, added, pool full, idle).
// An add answers once its node is filed into a slot; a zero delay or a full
// pool is answered from the pool check, without filing. A tick emits each
// expired timer of the current near slot in turn, and a near-wheel wrap
// re-files the timers of one level slot, bounded by the pool size. The walk
// over node memory, one node at a time, sets the rate; a command starts once
// the last result word is taken. A two-entry command queue lets new words in
// while the back end works. Reset clears the tick count; a clearing pass over
// every slot (508 by default) then empties them and refills the free pool,
// while the queue takes two words and then holds tready low.
// When the receiver stalls, the current result word holds and the back end
// waits; the queue keeps accepting until it is full.
module hierarchical_timing_wheel_unit #(
    parameter int NEAR_BITS   = 8,
    parameter int LEVEL_BITS  = 6,
    parameter int TIMER_SLOTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // delay[30:0], dest_handle, session
    input  logic         s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // out_handle, out_session
    output logic [1:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast
);

    htw_pkg::cmd_word_t in_word, q_word;
    logic q_valid, q_pop;

    assign in_word.cmd     = s_axis_tuser;
    assign in_word.delay   = s_axis_tdata[30:0];
    assign in_word.handle  = s_axis_tdata[62:31];
    assign in_word.session = s_axis_tdata[94:63];

    htw_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_word(in_word),
        .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
    );

    htw_back #(
        .NEAR_BITS(NEAR_BITS), .LEVEL_BITS(LEVEL_BITS), .TIMER_SLOTS(TIMER_SLOTS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
        .kind(m_axis_tuser), .out_handle(m_axis_tdata[31:0]),
        .out_session(m_axis_tdata[63:32]), .last(m_axis_tlast),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
    );

endmodule
